@@ rtl/sabh_pkg.sv @@
// ----------------------------------------------------------------------------
// sabh_pkg: shared types and constants
// Field widths, character constants, register indexes, FSM codes and the
// request/status structs between the core and the remainder unit.
// ----------------------------------------------------------------------------
package sabh_pkg;

  localparam int KEY_BYTE_W  = 8;
  localparam int HASH_W      = 32;
  localparam int SHIFT_W     = 5;
  localparam int BUCKET_W    = 20;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 20;

  localparam logic [KEY_BYTE_W-1:0] CHAR_A       = 8'h41;  // 'A'
  localparam logic [KEY_BYTE_W-1:0] CHAR_J       = 8'h4A;  // 'J'
  localparam logic [KEY_BYTE_W-1:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [KEY_BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;  // 'z'
  localparam logic [KEY_BYTE_W-1:0] CASE_OFFSET  = 8'h20;
  localparam logic [KEY_BYTE_W-1:0] NIBBLE_MASK  = 8'h0F;

  localparam logic [SHIFT_W-1:0] SHIFT_STEP = 5'd5;
  localparam logic [SHIFT_W-1:0] SHIFT_WRAP = 5'd25;
  localparam logic [SHIFT_W-1:0] SHIFT_DROP = 5'd24;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX  = 5'd24;

  localparam logic [BUCKET_W-1:0] BUCKET_COUNT_RESET = 20'd101;

  localparam logic [CFG_INDEX_W-1:0] REG_FOLD_CASE    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUCKET_COUNT = 4'd1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHAR  = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_LOAD  = 5'b10000
  } sabh_state_t;

  typedef struct packed {
    logic                start;
    logic [HASH_W-1:0]   dividend;
    logic [BUCKET_W-1:0] divisor;
  } sabh_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sabh_div_status_t;

endpackage

@@ rtl/sabh_key_if.sv @@
// ----------------------------------------------------------------------------
// sabh_key_if: key byte channel
// Valid/ready channel carrying one key byte and its flags per transfer.
// ----------------------------------------------------------------------------
interface sabh_key_if;
  import sabh_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KEY_BYTE_W-1:0] key_byte;
  logic                  binary_key;
  logic                  end_of_key;
  logic                  empty_key;

  modport source (output valid, output key_byte, output binary_key,
                  output end_of_key, output empty_key, input ready);
  modport sink   (input valid, input key_byte, input binary_key,
                  input end_of_key, input empty_key, output ready);
endinterface

@@ rtl/sabh_bucket_if.sv @@
// ----------------------------------------------------------------------------
// sabh_bucket_if: bucket index channel
// Valid/ready channel carrying one bucket index per transfer.
// ----------------------------------------------------------------------------
interface sabh_bucket_if;
  import sabh_pkg::*;

  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bucket_index;

  modport source (output valid, output bucket_index, input ready);
  modport sink   (input valid, input bucket_index, output ready);
endinterface

@@ rtl/sabh_cfg_if.sv @@
// ----------------------------------------------------------------------------
// sabh_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface sabh_cfg_if;
  import sabh_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/sabh_divmod.sv @@
// ----------------------------------------------------------------------------
// sabh_divmod: iterative remainder unit
// Restoring division, one quotient bit per cycle.
// Only the remainder is kept. done pulses the cycle after the last step.
// ----------------------------------------------------------------------------
module sabh_divmod (
  input  logic                          clk,
  input  logic                          rst,
  input  sabh_pkg::sabh_div_req_t       req,
  output sabh_pkg::sabh_div_status_t    status,
  output logic [sabh_pkg::BUCKET_W-1:0] remainder
);
  import sabh_pkg::*;

  localparam int STEPS  = HASH_W;
  localparam int CNT_W  = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [HASH_W-1:0]   dvd;
  logic [BUCKET_W-1:0] divisor;
  logic [BUCKET_W-1:0] rem;
  logic [BUCKET_W:0]   trial;
  logic [BUCKET_W:0]   diff;
  logic [BUCKET_W-1:0] rem_next;

  always_comb begin
    trial = {rem, dvd[HASH_W-1]};
    diff  = trial - {1'b0, divisor};
    // remainder stays below the divisor, so the low bits are enough
    rem_next = (trial >= {1'b0, divisor}) ? diff[BUCKET_W-1:0] : trial[BUCKET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      dvd <= {dvd[HASH_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign remainder   = rem;

endmodule

@@ rtl/shift_add_string_bucket_hash_core.sv @@
// ----------------------------------------------------------------------------
// shift_add_string_bucket_hash_core: shift-add key hash with bucket modulo
// Accumulates a 32-bit shift-add hash over key bytes and returns the hash
// modulo the configured bucket count at the end of each key.
// ----------------------------------------------------------------------------
// Usage:
//   key    : one key byte per transfer with binary_key, end_of_key and
//            empty_key flags. ready is high only while the core is idle.
//   bucket : one bucket_index per key, sent on the transfer ending the key.
//   cfg    : register writes (0 fold_case, 1 bucket_count), always ready;
//            write only while no key is in flight.
// Throughput: one character is hashed per cycle by the shared shift-add
//   unit in the char state; a binary byte yields two characters (low
//   nibble, then high). Key bytes are not taken while a byte is hashed.
// Result path: a key-ending item passes the start state, the bit-serial
//   remainder unit (one quotient bit per cycle over 32 bits) and the load
//   state; with a zero bucket_count the remainder unit is skipped and the
//   index is 0.
// Stall: the result sits in an output register; the core keeps taking key
//   bytes while it waits and only holds in the load state if a second
//   result is ready before the first is taken.
// Reset: rst (synchronous) clears the hash, the shift, the output valid and
//   restores fold_case = 0, bucket_count = 101.
// ----------------------------------------------------------------------------
module shift_add_string_bucket_hash_core (
  input  logic         clk,
  input  logic         rst,
  sabh_key_if.sink     key,
  sabh_bucket_if.source bucket,
  sabh_cfg_if.sink     cfg
);
  import sabh_pkg::*;

  sabh_state_t         state;
  logic                fold_case;
  logic [BUCKET_W-1:0] bucket_count;
  logic [HASH_W-1:0]   acc;
  logic [SHIFT_W-1:0]  shift_amount;

  logic [KEY_BYTE_W-1:0] byte_q;
  logic                  bin_q;
  logic                  last_q;
  logic                  step_q;

  logic                out_valid;
  logic [BUCKET_W-1:0] out_data;
  logic [BUCKET_W-1:0] result_q;

  sabh_div_req_t       div_req;
  sabh_div_status_t    div_stat;
  logic [BUCKET_W-1:0] div_rem;

  logic                  key_xfer;
  logic                  has_char;
  logic                  out_free;
  logic [KEY_BYTE_W-1:0] nibble;
  logic [KEY_BYTE_W-1:0] bin_char;
  logic [KEY_BYTE_W-1:0] text_char;
  logic [KEY_BYTE_W-1:0] cur_char;
  logic [HASH_W-1:0]     char_ext;
  logic [HASH_W-1:0]     acc_next;
  logic [SHIFT_W-1:0]    shift_inc;
  logic [SHIFT_W-1:0]    shift_next;

  assign key.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign key_xfer  = key.valid && key.ready;
  assign has_char  = !key.empty_key && (key.binary_key || (key.key_byte != '0));
  assign out_free  = !out_valid || bucket.ready;

  // shared shift-add unit: one character per cycle
  always_comb begin
    nibble    = (step_q ? (byte_q >> 4) : byte_q) & NIBBLE_MASK;
    bin_char  = (step_q ? CHAR_J : CHAR_A) + nibble;
    text_char = (fold_case && (byte_q >= CHAR_LOWER_A) && (byte_q <= CHAR_LOWER_Z))
                ? (byte_q - CASE_OFFSET) : byte_q;
    cur_char  = bin_q ? bin_char : text_char;
    char_ext  = {{(HASH_W-KEY_BYTE_W){cur_char[KEY_BYTE_W-1]}}, cur_char};
    acc_next  = acc + (char_ext << shift_amount);
    shift_inc = shift_amount + SHIFT_STEP;
    shift_next = (shift_inc >= SHIFT_WRAP) ? (shift_inc - SHIFT_DROP) : shift_inc;
  end

  always_comb begin
    div_req.start    = (state == ST_START) && (bucket_count != '0);
    div_req.dividend = acc;
    div_req.divisor  = bucket_count;
  end

  sabh_divmod u_divmod (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .status    (div_stat),
    .remainder (div_rem)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_case    <= 1'b0;
      bucket_count <= BUCKET_COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_FOLD_CASE:    fold_case    <= cfg.data[0];
        REG_BUCKET_COUNT: bucket_count <= cfg.data;
        default:          ;
      endcase
    end
  end

  // sequencer, hash state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      acc          <= '0;
      shift_amount <= '0;
      out_valid    <= 1'b0;
    end else begin
      // a new result load wins over the transfer of the old one
      if (state == ST_LOAD && out_free) begin
        out_valid <= 1'b1;
      end else if (bucket.valid && bucket.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (key_xfer) begin
            if (has_char) begin
              state <= ST_CHAR;
            end else if (key.end_of_key) begin
              state <= ST_START;
            end
          end
        end
        ST_CHAR: begin
          acc          <= acc_next;
          shift_amount <= shift_next;
          if (bin_q && !step_q) begin
            state <= ST_CHAR;
          end else if (last_q) begin
            state <= ST_START;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_START: begin
          state <= (bucket_count == '0) ? ST_LOAD : ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            acc          <= '0;
            shift_amount <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (key_xfer) begin
      byte_q <= key.key_byte;
      bin_q  <= key.binary_key;
      last_q <= key.end_of_key;
      step_q <= 1'b0;
    end else if (state == ST_CHAR) begin
      step_q <= 1'b1;
    end
    if (state == ST_START) begin
      result_q <= '0;
    end else if (state == ST_DIV && div_stat.done) begin
      result_q <= div_rem;
    end
    if (state == ST_LOAD && out_free) begin
      out_data <= result_q;
    end
  end

  assign bucket.valid        = out_valid;
  assign bucket.bucket_index = out_data;

`ifndef SYNTHESIS
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    shift_amount <= SHIFT_MAX)
    else $error("shift amount out of range");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && out_free) |=> (out_valid && acc == '0 && shift_amount == '0))
    else $error("result load did not clear hash state");

  a_result_below_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bucket_count != '0) |-> (bucket.bucket_index < bucket_count))
    else $error("bucket index not below bucket count");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("remainder done outside divide state");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !key.ready)
    else $error("key ready while remainder unit busy");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for shift_add_string_bucket_hash_core
// Streams key bytes (text, binary, empty and zero bytes) under several
// register settings. A behavioral hash model predicts every bucket index,
// and each transfer on the bucket channel is checked in order.
// ----------------------------------------------------------------------------
module tb;
  import sabh_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 28;
  localparam int RANDOM_ITEMS = 1580;
  localparam int PHASE_ITEMS  = 250;

  // index with no register behind it; a write must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 4'd15;

  typedef struct packed {
    logic [KEY_BYTE_W-1:0] key_byte;
    logic                  binary_key;
    logic                  end_of_key;
    logic                  empty_key;
  } key_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sabh_key_if    key_ch ();
  sabh_bucket_if bucket_ch ();
  sabh_cfg_if    cfg_ch ();

  shift_add_string_bucket_hash_core u_top (
    .clk    (clk),
    .rst    (rst),
    .key    (key_ch),
    .bucket (bucket_ch),
    .cfg    (cfg_ch)
  );

  // hash model state and register copies
  logic                fold_en;
  logic [BUCKET_W-1:0] bucket_div;
  logic [HASH_W-1:0]   hash_acc;
  logic [SHIFT_W-1:0]  shift_amt;
  logic [BUCKET_W-1:0] pending_buckets[$];

  int errors     = 0;
  int cycles     = 0;
  int items_sent = 0;
  bit steady     = 1'b0;  // no idling on either side while set

  always #10 clk = ~clk;

  function automatic key_item_t make_item(input logic [KEY_BYTE_W-1:0] b, input logic bin,
                                          input logic last, input logic empty);
    key_item_t it;
    it.key_byte   = b;
    it.binary_key = bin;
    it.end_of_key = last;
    it.empty_key  = empty;
    return it;
  endfunction

  function automatic void add_char(input logic [KEY_BYTE_W-1:0] c);
    logic [HASH_W-1:0] ext;
    ext       = {{(HASH_W-KEY_BYTE_W){c[KEY_BYTE_W-1]}}, c};
    hash_acc  = hash_acc + (ext << shift_amt);
    shift_amt = shift_amt + SHIFT_STEP;
    if (shift_amt >= SHIFT_WRAP) begin
      shift_amt = shift_amt - SHIFT_DROP;
    end
  endfunction

  function automatic void hash_key_item(input key_item_t it);
    logic [KEY_BYTE_W-1:0] c;
    logic [HASH_W-1:0]     rem;
    c = it.key_byte;
    if (!it.empty_key) begin
      if (it.binary_key) begin
        add_char(CHAR_A + (c & NIBBLE_MASK));
        add_char(CHAR_J + ((c >> 4) & NIBBLE_MASK));
      end else if (c != 8'h00) begin
        if (fold_en && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
          c = c - CASE_OFFSET;
        end
        add_char(c);
      end
    end
    if (it.end_of_key) begin
      if (bucket_div == {BUCKET_W{1'b0}}) begin
        pending_buckets.push_back({BUCKET_W{1'b0}});
      end else begin
        rem = hash_acc % {{(HASH_W-BUCKET_W){1'b0}}, bucket_div};
        pending_buckets.push_back(rem[BUCKET_W-1:0]);
      end
      hash_acc  = '0;
      shift_amt = '0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic send_key(input key_item_t it);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      key_ch.valid <= 1'b0;
      @(posedge clk);
    end
    key_ch.valid      <= 1'b1;
    key_ch.key_byte   <= it.key_byte;
    key_ch.binary_key <= it.binary_key;
    key_ch.end_of_key <= it.end_of_key;
    key_ch.empty_key  <= it.empty_key;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    hash_key_item(it);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_FOLD_CASE) begin
      fold_en = val[0];
    end else if (idx == REG_BUCKET_COUNT) begin
      bucket_div = val[BUCKET_W-1:0];
    end
    @(posedge clk);
  endtask

  // wait for every result, then for a key byte still being hashed
  task automatic settle();
    key_ch.valid <= 1'b0;
    while (pending_buckets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic key_item_t random_byte_item(input bit bin_mode);
    key_item_t it;
    int        pick;
    pick          = $urandom_range(99);
    it.key_byte   = 8'($urandom_range(255));
    it.binary_key = ($urandom_range(99) < 10) ? !bin_mode : bin_mode;
    it.end_of_key = 1'b0;
    it.empty_key  = (pick < 4);
    if (!it.binary_key && pick >= 4 && pick < 7) begin
      it.key_byte = 8'h00;
    end else if (!it.binary_key && pick >= 7 && pick < 50) begin
      it.key_byte = $urandom_range(1) ? CHAR_LOWER_A + 8'($urandom_range(25))
                                      : CHAR_A + 8'($urandom_range(25));
    end
    return it;
  endfunction

  task automatic send_random_key(input bit long_key);
    int        len;
    bit        bin_mode;
    bit        ended;
    key_item_t it;
    len      = long_key ? $urandom_range(20, 48) : $urandom_range(0, 9);
    bin_mode = ($urandom_range(99) < 30);
    ended    = 1'b0;
    for (int i = 0; i < len; i++) begin
      it            = random_byte_item(bin_mode);
      it.end_of_key = (i == len - 1) && ($urandom_range(99) >= 10);
      ended         = it.end_of_key;
      send_key(it);
    end
    // key closed by an empty item
    if (!ended) begin
      send_key(make_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, 1'b1));
    end
  endtask

  function automatic logic [BUCKET_W-1:0] pick_bucket_count();
    case ($urandom_range(9))
      0:       return BUCKET_COUNT_RESET;
      1:       return 20'd900001;
      2:       return 20'($urandom_range(0, 100));
      3:       return 20'($urandom_range(900002, 20'hFFFFF));
      default: return 20'($urandom_range(101, 900001));
    endcase
  endfunction

  task automatic test_directed();
    string phrase;
    phrase = "Hash Key!";
    send_key(make_item(8'hA5, 1'b0, 1'b1, 1'b1));  // empty key
    send_key(make_item(8'h00, 1'b0, 1'b1, 1'b0));  // lone zero text byte
    send_key(make_item(8'hFF, 1'b0, 1'b1, 1'b0));  // sign extension
    send_key(make_item(8'h80, 1'b0, 1'b0, 1'b0));
    send_key(make_item(8'h7F, 1'b0, 1'b1, 1'b0));
    send_key(make_item(8'h00, 1'b1, 1'b0, 1'b0));  // binary nibble extremes
    send_key(make_item(8'hFF, 1'b1, 1'b1, 1'b0));
    send_key(make_item(CHAR_LOWER_A, 1'b0, 1'b0, 1'b0));  // no folding yet
    send_key(make_item(8'h00, 1'b0, 1'b0, 1'b0));         // zero byte mid-key
    send_key(make_item(8'h3C, 1'b1, 1'b0, 1'b1));         // empty, not last
    send_key(make_item(CHAR_LOWER_Z, 1'b0, 1'b1, 1'b0));
    // long enough for the shift to wrap
    for (int i = 0; i < phrase.len(); i++) begin
      send_key(make_item(phrase[i], 1'b0, i == phrase.len() - 1, 1'b0));
    end
    send_key(make_item(8'h51, 1'b0, 1'b0, 1'b0));
    send_key(make_item(8'hC3, 1'b1, 1'b1, 1'b1));  // empty item ends a key
  endtask

  task automatic test_fold_case();
    string phrase;
    phrase = "az{`@AZ";
    settle();
    write_reg(REG_FOLD_CASE, {19'($urandom_range(20'h7FFFF)), 1'b1});
    for (int i = 0; i < phrase.len(); i++) begin
      send_key(make_item(phrase[i], 1'b0, i == phrase.len() - 1, 1'b0));
    end
    send_key(make_item(8'h6A, 1'b1, 1'b1, 1'b0));  // nibble letters ignore folding
  endtask

  task automatic test_bucket_extremes();
    logic [BUCKET_W-1:0] counts[6];
    counts = '{20'd0, 20'd1, 20'd2, 20'd900001, 20'hFFFFF, BUCKET_COUNT_RESET};
    foreach (counts[k]) begin
      settle();
      write_reg(REG_BUCKET_COUNT, counts[k]);
      write_reg(REG_FOLD_CASE, {19'($urandom_range(20'h7FFFF)), k[0]});
      repeat (4) send_random_key(1'b0);
    end
    settle();
    write_reg(REG_UNMAPPED, 20'hFFFFF);
    repeat (3) send_random_key(1'b0);
    settle();
    write_reg(REG_UNMAPPED, 20'h00000);
    repeat (3) send_random_key(1'b0);
  endtask

  task automatic test_random_traffic();
    int goal;
    int phase;
    int phase_start;
    goal  = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < goal) begin
      settle();
      write_reg(REG_FOLD_CASE, 20'($urandom_range(20'hFFFFF)));
      write_reg(REG_BUCKET_COUNT, pick_bucket_count());
      steady      = (phase == 3);
      phase_start = items_sent;
      while (items_sent < goal && items_sent - phase_start < PHASE_ITEMS) begin
        send_random_key($urandom_range(99) < 5);
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    bucket_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_results
    logic [BUCKET_W-1:0] want;
    if (!rst && bucket_ch.valid && bucket_ch.ready) begin
      if (pending_buckets.size() == 0) begin
        report_mismatch($sformatf("unexpected bucket_index %0d", bucket_ch.bucket_index));
      end else begin
        want = pending_buckets.pop_front();
        if (bucket_ch.bucket_index !== want) begin
          report_mismatch($sformatf("bucket_index %0d, predicted %0d",
                                    bucket_ch.bucket_index, want));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    key_ch.valid      = 1'b0;
    key_ch.key_byte   = '0;
    key_ch.binary_key = 1'b0;
    key_ch.end_of_key = 1'b0;
    key_ch.empty_key  = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    fold_en           = 1'b0;
    bucket_div        = BUCKET_COUNT_RESET;
    hash_acc          = '0;
    shift_amt         = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fold_case();
    test_bucket_extremes();
    test_random_traffic();
    settle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
